>>> design/tbcld_pkg.sv
// Package for the two-bit canvas line drawer: sizes, command codes,
// register indexes, transaction structs and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbcld_pkg;

   // canvas capacity
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(DEPTH);

   // field widths
   localparam int CMD_W   = 2;
   localparam int COORD_W = 6;
   localparam int LEN_W   = 8;
   localparam int CFG_W   = 7;
   localparam int CODE_W  = 2;
   localparam int MARK_W  = 7;

   // width that holds a saturated dimension, a clipped bound and a cell count
   localparam int MAXW_W = $clog2(MAX_WIDTH + 1);
   localparam int MAXH_W = $clog2(MAX_HEIGHT + 1);
   localparam int MAXD_W = (MAXW_W > MAXH_W) ? MAXW_W : MAXH_W;
   localparam int DIM_W  = (MAXD_W > CFG_W) ? MAXD_W : CFG_W;
   // signed width for run end points before clipping
   localparam int SPOS_W = DIM_W + 3;

   // register file
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'd1;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd20;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd10;

   // command codes
   localparam logic [CMD_W-1:0] CMD_HLINE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_VLINE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [COORD_W-1:0]        col;
      logic [COORD_W-1:0]        row;
      logic signed [LEN_W-1:0]   length;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] cell_code;
      logic [MARK_W-1:0] cells_marked;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;   // capture the request
      logic prep;    // clip the run, register bounds
      logic calc;    // form the first cell address
      logic draw;    // write one cell, advance
      logic clear;   // write one zero cell of the clearing sweep
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic draw_go;
      logic read_ok;
      logic last_cell;
   } sts_type;

endpackage

`default_nettype wire

>>> design/tbcld_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tbcld_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/tbcld_ctrl.sv
// Controller state machine of the line drawer: clearing sweep, command
// sequencing, result strobe. Depends on tbcld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbcld_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire tbcld_pkg::sts_type sts,
   output tbcld_pkg::ctl_type     ctl,
   output logic                   busy,
   output logic                   rsp_valid
);
   import tbcld_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_PREP  = 7'b0000100,
      S_CALC  = 7'b0001000,
      S_DRAW  = 7'b0010000,
      S_READ  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (sts.clr_last) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_PREP;
         S_PREP:  state_in = S_CALC;
         S_CALC: begin
            if (sts.draw_go) begin
               state_in = S_DRAW;
            end else if (sts.read_ok) begin
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DRAW:  if (sts.last_cell) state_in = S_RESP;
         S_READ:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ctl.latch = (state_ff == S_IDLE) && start;
      ctl.prep  = (state_ff == S_PREP);
      ctl.calc  = (state_ff == S_CALC);
      ctl.draw  = (state_ff == S_DRAW);
      ctl.clear = (state_ff == S_CLEAR);
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

`default_nettype wire

>>> design/tbcld_dp.sv
// Datapath of the line drawer: size registers, run clipping, cell address
// generation and the two bit-plane stores. Depends on tbcld_pkg, tbcld_ram.
`timescale 1ns / 1ps
`default_nettype none

module tbcld_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tbcld_pkg::ctl_type               ctl,
   output tbcld_pkg::sts_type                    sts,
   input  wire tbcld_pkg::req_type               req_data,
   output tbcld_pkg::rsp_type                    rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [tbcld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tbcld_pkg::CFG_W-1:0]      csr_wdata
);
   import tbcld_pkg::*;

   localparam int SUM_W = 2 * DIM_W + 1;

   logic [CFG_W-1:0]  width_ff, height_ff;
   req_type           req_ff;
   logic [DIM_W-1:0]  w_ff, w_in;
   logic [DIM_W-1:0]  lo_ff, lo_in;
   logic [DIM_W-1:0]  count_ff, count_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic              draw_go_ff, draw_go_in;
   logic              read_ok_ff, read_ok_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] clr_addr_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         req_ff <= req_data;
      end
   end

   // run clipping
   logic [DIM_W-1:0]        w_sat, h_sat, lim;
   logic                    is_h, is_v, in_range;
   logic [COORD_W-1:0]      start_u;
   logic signed [SPOS_W-1:0] start_s, len_s, lim_s, a_s, b_s, a_c, b_c, cnt_s;

   always_comb begin
      w_sat = (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                      : DIM_W'(width_ff);
      h_sat = (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                        : DIM_W'(height_ff);
      is_h     = (req_ff.cmd == CMD_HLINE);
      is_v     = (req_ff.cmd == CMD_VLINE);
      in_range = (DIM_W'(req_ff.col) < w_sat) && (DIM_W'(req_ff.row) < h_sat);
      start_u  = is_h ? req_ff.col : req_ff.row;
      lim      = is_h ? w_sat : h_sat;
      start_s  = $signed({{(SPOS_W-COORD_W){1'b0}}, start_u});
      len_s    = $signed({{(SPOS_W-LEN_W){req_ff.length[LEN_W-1]}}, req_ff.length});
      lim_s    = $signed({{(SPOS_W-DIM_W){1'b0}}, lim});
      if (len_s > 0) begin
         a_s = start_s;
         b_s = start_s + len_s - SPOS_W'(1);
      end else begin
         a_s = start_s + len_s + SPOS_W'(1);
         b_s = start_s;
      end
      a_c   = (a_s < 0) ? '0 : a_s;
      b_c   = (b_s > lim_s - SPOS_W'(1)) ? lim_s - SPOS_W'(1) : b_s;
      cnt_s = b_c - a_c + SPOS_W'(1);
      lo_in      = a_c[DIM_W-1:0];
      count_in   = cnt_s[DIM_W-1:0];
      w_in       = w_sat;
      draw_go_in = (is_h || is_v) && in_range && (req_ff.length != '0);
      read_ok_in = (req_ff.cmd == CMD_READ) && in_range;
   end

   // first cell address: base row times width plus column; each drawn cell steps it by one or by the width
   logic [DIM_W-1:0] mul_a, add_b, stride;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] step_sum;

   always_comb begin
      mul_a    = (req_ff.cmd == CMD_VLINE) ? lo_ff : DIM_W'(req_ff.row);
      add_b    = (req_ff.cmd == CMD_HLINE) ? lo_ff : DIM_W'(req_ff.col);
      sum      = SUM_W'(mul_a) * SUM_W'(w_ff) + SUM_W'(add_b);
      stride   = (req_ff.cmd == CMD_VLINE) ? w_ff : DIM_W'(1);
      step_sum = SUM_W'(addr_ff) + SUM_W'(stride);
      if (ctl.calc) begin
         addr_in = sum[ADDR_W-1:0];
      end else if (ctl.draw) begin
         addr_in = step_sum[ADDR_W-1:0];
      end else begin
         addr_in = addr_ff;
      end
      if (ctl.calc) begin
         rem_in = count_ff;
      end else if (ctl.draw) begin
         rem_in = rem_ff - DIM_W'(1);
      end else begin
         rem_in = rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prep) begin
         lo_ff      <= lo_in;
         count_ff   <= count_in;
         w_ff       <= w_in;
         draw_go_ff <= draw_go_in;
         read_ok_ff <= read_ok_in;
      end
      addr_ff <= addr_in;
      rem_ff  <= rem_in;
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (ctl.clear) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   // bit planes: horizontal marks and vertical marks
   logic              h_we, v_we, h_q, v_q;
   logic [ADDR_W-1:0] waddr;

   assign h_we  = ctl.clear || (ctl.draw && req_ff.cmd == CMD_HLINE);
   assign v_we  = ctl.clear || (ctl.draw && req_ff.cmd == CMD_VLINE);
   assign waddr = ctl.clear ? clr_addr_ff : addr_ff;

   tbcld_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_hplane (
      .clock (clock),
      .we    (h_we),
      .waddr (waddr),
      .wdata (!ctl.clear),
      .raddr (addr_ff),
      .rdata (h_q)
   );

   tbcld_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vplane (
      .clock (clock),
      .we    (v_we),
      .waddr (waddr),
      .wdata (!ctl.clear),
      .raddr (addr_ff),
      .rdata (v_q)
   );

   always_comb begin
      sts.clr_last  = (clr_addr_ff == ADDR_W'(DEPTH - 1));
      sts.draw_go   = draw_go_ff;
      sts.read_ok   = read_ok_ff;
      sts.last_cell = (rem_ff == DIM_W'(1));
      rsp_data.cell_code    = read_ok_ff ? {v_q, h_q} : '0;
      rsp_data.cells_marked = draw_go_ff ? count_ff[MARK_W-1:0] : '0;
   end

endmodule

`default_nettype wire

>>> design/two_bit_canvas_line_drawer_unit.sv
// Two-bit canvas line drawer, top level.
// Ties the controller (tbcld_ctrl) to the datapath (tbcld_dp); uses tbcld_pkg.
//
// Usage:
//  - Command channel: a transaction (req_data) is taken on a rising edge
//    with start high and busy low. busy stays high until the result is out.
//  - Result channel: rsp_valid is high for exactly one cycle with rsp_data;
//    the receiver cannot stall it. Every command gives one result.
//  - Register port: csr_we/csr_index/csr_wdata write canvas width (index 0)
//    or height (index 1) at once; write only while busy is low.
//  - Sequence: an accepted command passes the prep and calc states; then a read
//    passes the read state, a draw writes its N cells (N the cells marked, at
//    most 64) one per cycle through the write port of one bit plane, and a
//    dropped command goes straight to the strobe. The next command is taken
//    at the edge ending the cycle after the strobe.
//  - Reset: synchronous. It restores width 20 / height 10 and starts a
//    clearing sweep that zeroes all 4096 cells; busy is high
//    during the sweep, register writes are still taken.
`timescale 1ns / 1ps
`default_nettype none

module two_bit_canvas_line_drawer_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire tbcld_pkg::req_type              req_data,
   output logic                                 rsp_valid,
   output tbcld_pkg::rsp_type                   rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [tbcld_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tbcld_pkg::CFG_W-1:0]     csr_wdata
);
   import tbcld_pkg::*;

   ctl_type ctl;
   sts_type sts;

   tbcld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tbcld_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

>>> design/tbcld_checker.sv
// Port-level checker for the line drawer and its bind to the top level.
// Depends on tbcld_pkg and two_bit_canvas_line_drawer_unit.
`timescale 1ns / 1ps
`default_nettype none

module tbcld_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire tbcld_pkg::rsp_type rsp_data
);
   import tbcld_pkg::*;

   // reset always launches the clearing sweep
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transaction accepted but busy not raised");

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 (!busy && !rsp_valid))
      else $error("result strobe not followed by idle");

   a_draw_or_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.cells_marked != '0) |-> (rsp_data.cell_code == '0))
      else $error("result carries both a cell code and a mark count");

endmodule

bind two_bit_canvas_line_drawer_unit tbcld_checker u_tbcld_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> sim/testbench.sv
// Testbench for the two-bit canvas line drawer: random and directed draw/read
// commands checked against a canvas predictor. Needs tbcld_pkg and
// two_bit_canvas_line_drawer_unit.
`timescale 1ns / 1ps

module testbench;
   import tbcld_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 80;
   localparam int CALM_TAIL = 200;   // no idling once this few commands remain

   typedef struct {
      bit                   is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     val;
      req_type              req;
   } stim_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   two_bit_canvas_line_drawer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // canvas predictor state
   bit [1:0]       canvas_cells [DEPTH];
   logic [CFG_W-1:0] model_width  = WIDTH_RESET;
   logic [CFG_W-1:0] model_height = HEIGHT_RESET;

   stim_type  cmd_backlog[$];
   rsp_type   canvas_rsp_q[$];
   int        accepted_count;
   int        result_count;
   int        mismatch_count = 0;
   int        idle_left;
   int        cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_canvas_op(req_type r);
      rsp_type res;
      int w, h, col, row, len, lo, hi;
      res = '0;
      w = (model_width > MAX_WIDTH) ? MAX_WIDTH : int'(model_width);
      h = (model_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(model_height);
      col = int'(r.col);
      row = int'(r.row);
      len = int'($signed(r.length));
      if (r.cmd == CMD_HLINE || r.cmd == CMD_VLINE) begin
         if (col < w && row < h && len != 0) begin
            if (len > 0) begin
               lo = (r.cmd == CMD_HLINE) ? col : row;
               hi = lo + len - 1;
            end else begin
               hi = (r.cmd == CMD_HLINE) ? col : row;
               lo = hi + len + 1;
            end
            if (lo < 0) lo = 0;
            if (r.cmd == CMD_HLINE) begin
               if (hi > w - 1) hi = w - 1;
               for (int i = lo; i <= hi; i++) canvas_cells[row * w + i] |= 2'b01;
            end else begin
               if (hi > h - 1) hi = h - 1;
               for (int i = lo; i <= hi; i++) canvas_cells[i * w + col] |= 2'b10;
            end
            res.cells_marked = MARK_W'(hi - lo + 1);
         end
      end else if (r.cmd == CMD_READ) begin
         if (col < w && row < h) res.cell_code = canvas_cells[row * w + col];
      end
      return res;
   endfunction

   function automatic req_type make_req(logic [CMD_W-1:0] cmd, int col, int row, int len);
      req_type r;
      r.cmd = cmd;
      r.col = COORD_W'(col);
      r.row = COORD_W'(row);
      r.length = LEN_W'(len);
      return r;
   endfunction

   task automatic queue_cmd(req_type r);
      stim_type e;
      e.is_cfg = 1'b0;
      e.idx = '0;
      e.val = '0;
      e.req = r;
      cmd_backlog.push_back(e);
   endtask

   task automatic queue_size(int w, int h);
      stim_type e;
      e.is_cfg = 1'b1;
      e.req = '0;
      e.idx = CSR_WIDTH;
      e.val = CFG_W'(w);
      cmd_backlog.push_back(e);
      e.idx = CSR_HEIGHT;
      e.val = CFG_W'(h);
      cmd_backlog.push_back(e);
   endtask

   // Mostly draws and reads that land on the canvas, with some off-canvas noise and unused commands.
   function automatic req_type random_req(int w, int h);
      int ew, eh, pick, col, row, len;
      logic [CMD_W-1:0] cmd;
      ew = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      pick = $urandom_range(0, 99);
      if (pick < 36) cmd = CMD_HLINE;
      else if (pick < 72) cmd = CMD_VLINE;
      else if (pick < 96) cmd = CMD_READ;
      else cmd = CMD_UNUSED;
      col = (ew > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, ew - 1)
                                                 : $urandom_range(0, 63);
      row = (eh > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, eh - 1)
                                                 : $urandom_range(0, 63);
      pick = $urandom_range(0, 99);
      if (pick < 45) len = $urandom_range(1, 8);
      else if (pick < 75) len = $urandom_range(1, 64);
      else if (pick < 95) len = $urandom_range(0, 255);
      else len = 0;
      if (pick < 75 && $urandom_range(0, 1) == 1) len = -len;
      return make_req(cmd, col, row, len);
   endfunction

   // driver: presents commands and register writes from the backlog
   always @(posedge clock) begin : drv
      logic start_n;
      logic we_n;
      stim_type e;
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         csr_we <= 1'b0;
         csr_index <= CSR_WIDTH;
         csr_wdata <= '0;
         idle_left <= 0;
         accepted_count <= 0;
      end else begin
         start_n = start;
         we_n = 1'b0;
         if (start && !busy) begin
            canvas_rsp_q.push_back(predict_canvas_op(req_data));
            accepted_count <= accepted_count + 1;
            start_n = 1'b0;
         end
         if (!start_n && cmd_backlog.size() > 0) begin
            e = cmd_backlog[0];
            if (e.is_cfg) begin
               // only with nothing in flight
               if (!start && !busy && accepted_count == result_count) begin
                  if (e.idx == CSR_WIDTH) model_width = e.val;
                  else model_height = e.val;
                  csr_index <= e.idx;
                  csr_wdata <= e.val;
                  we_n = 1'b1;
                  void'(cmd_backlog.pop_front());
               end
            end else if (idle_left > 0) begin
               idle_left <= idle_left - 1;
            end else if (cmd_backlog.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
               idle_left <= $urandom_range(0, 2);
            end else begin
               req_data <= e.req;
               start_n = 1'b1;
               void'(cmd_backlog.pop_front());
            end
         end
         start <= start_n;
         csr_we <= we_n;
      end
   end

   task automatic report_mismatch(string what, rsp_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected code %0d marked %0d, got code %0d marked %0d",
                  $realtime, what, want.cell_code, want.cells_marked,
                  rsp_data.cell_code, rsp_data.cells_marked);
   endtask

   // monitor: one result per strobe, in order
   always @(posedge clock) begin : mon
      rsp_type want;
      if (reset) begin
         result_count <= 0;
      end else if (rsp_valid) begin
         result_count <= result_count + 1;
         if (canvas_rsp_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding", '0);
         end else begin
            want = canvas_rsp_q.pop_front();
            if (rsp_data.cell_code !== want.cell_code ||
                rsp_data.cells_marked !== want.cells_marked)
               report_mismatch("result mismatch", want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : stim
      int sizes [12][2];
      int n;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;

      // directed part at the reset size (20 x 10)
      queue_cmd(make_req(CMD_READ, 0, 0, 0));
      queue_cmd(make_req(CMD_HLINE, 0, 0, 5));
      queue_cmd(make_req(CMD_HLINE, 19, 9, -128));
      queue_cmd(make_req(CMD_HLINE, 10, 3, 127));
      queue_cmd(make_req(CMD_VLINE, 0, 0, 64));
      queue_cmd(make_req(CMD_VLINE, 19, 9, -1));
      queue_cmd(make_req(CMD_VLINE, 5, 5, -64));
      queue_cmd(make_req(CMD_HLINE, 3, 3, 0));
      queue_cmd(make_req(CMD_VLINE, 3, 3, 0));
      queue_cmd(make_req(CMD_HLINE, 20, 0, 3));     // starts right of the canvas
      queue_cmd(make_req(CMD_VLINE, 0, 10, 3));     // starts below the canvas
      queue_cmd(make_req(CMD_HLINE, 63, 63, 1));
      queue_cmd(make_req(CMD_READ, 0, 0, 0));
      queue_cmd(make_req(CMD_READ, 1, 0, 0));
      queue_cmd(make_req(CMD_READ, 0, 1, 0));
      queue_cmd(make_req(CMD_READ, 19, 9, 0));
      queue_cmd(make_req(CMD_READ, 20, 0, 0));
      queue_cmd(make_req(CMD_READ, 63, 63, 0));
      queue_cmd(make_req(CMD_UNUSED, 63, 63, -1));
      // full canvas corners
      queue_size(64, 64);
      queue_cmd(make_req(CMD_HLINE, 63, 63, 64));
      queue_cmd(make_req(CMD_HLINE, 63, 0, -128));
      queue_cmd(make_req(CMD_VLINE, 63, 63, -64));
      queue_cmd(make_req(CMD_VLINE, 0, 0, 127));
      queue_cmd(make_req(CMD_READ, 63, 63, 0));

      // random phases; zero and above-max register values included
      sizes = '{'{20, 10}, '{64, 64}, '{1, 1}, '{0, 7}, '{64, 127}, '{127, 0},
                '{1, 64}, '{64, 1}, '{33, 17}, '{0, 0}, '{0, 0}, '{0, 0}};
      for (int p = 9; p < 12; p++) begin
         sizes[p][0] = $urandom_range(1, 64);
         sizes[p][1] = $urandom_range(1, 64);
      end
      for (int p = 0; p < 12; p++) begin
         queue_size(sizes[p][0], sizes[p][1]);
         n = (sizes[p][0] == 0 || sizes[p][1] == 0) ? 60 : 140;
         for (int i = 0; i < n; i++) queue_cmd(random_req(sizes[p][0], sizes[p][1]));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() > 0 || start || canvas_rsp_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && canvas_rsp_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> two_bit_canvas_line_drawer_unit.f
design/tbcld_pkg.sv
design/tbcld_ram.sv
design/tbcld_ctrl.sv
design/tbcld_dp.sv
design/two_bit_canvas_line_drawer_unit.sv
design/tbcld_checker.sv
sim/testbench.sv
